@@ design/lpfd_pkg.sv @@
package lpfd_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_BODY    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_MAGIC   = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_TYPE    = 2'd2;
  localparam logic [1:0] ERR_LENGTH  = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_MAGIC    = 3'd0;
  localparam logic [2:0] CFG_VERSION  = 3'd1;
  localparam logic [2:0] CFG_TYPE_LO  = 3'd2;
  localparam logic [2:0] CFG_TYPE_HI  = 3'd3;
  localparam logic [2:0] CFG_MAX_LEN  = 3'd4;

  // register reset values
  localparam logic [15:0] RST_MAGIC    = 16'h4348;
  localparam logic [7:0]  RST_VERSION  = 8'd1;
  localparam logic [7:0]  RST_TYPE_LO  = 8'd1;
  localparam logic [7:0]  RST_TYPE_HI  = 8'd2;
  localparam logic [31:0] RST_MAX_LEN  = 32'd1048576;

  localparam int HDR_BITS = 64;

  // configuration set seen by the header checker
  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  type_lo;
    logic [7:0]  type_hi;
    logic [31:0] max_len;
  } cfg_t;

  // header check verdict
  typedef struct packed {
    logic        bad;
    logic [1:0]  code;
    logic        empty;
    logic [7:0]  msg_type;
    logic [31:0] len;
  } hdr_chk_t;

endpackage

@@ design/length_prefixed_frame_deframer_core.sv @@
// channel   handshake              payload
// -------   ---------------------  ------------------------------------------------
// input     in_valid / in_ready    stream_byte[7:0], chunk_end
// output    out_valid / out_ready  result_kind[1:0], message_type[7:0],
//                                  body_byte[7:0], last_of_message, error_code[1:0]
// config    cfg_we                 cfg_index[2:0], cfg_data[31:0]
//
// one input beat per cycle unless the output stalls; a beat waits in the input
// register and its result, if any, enters the output register as the beat leaves.
// the single-pass step (header check, body count, discard) between the two registers
// sets the rate; the input register is refilled in the cycle it drains.
// rst is synchronous and clears the phase, counters and both valid flags.
// a stalled output holds the input register, which then keeps in_ready low.
module length_prefixed_frame_deframer_core import lpfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        chunk_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  message_type,
  output logic [7:0]  body_byte,
  output logic        last_of_message,
  output logic [1:0]  error_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_end;

  // parser state
  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [55:0] header_shift, header_shift_next;
  logic [31:0] body_remaining, body_remaining_next;
  logic [7:0]  current_type, current_type_next;

  logic        out_free;
  logic        advance;
  logic [31:0] rem_dec;
  hdr_chk_t    chk;

  // result of this step
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_type;
  logic [7:0] res_byte;
  logic       res_last;
  logic [1:0] res_code;

  assign out_free = !out_valid || out_ready;
  assign advance  = s_valid && out_free;
  assign in_ready = !s_valid || advance;
  assign rem_dec  = body_remaining - 32'd1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic   <= RST_MAGIC;
      cfg.version <= RST_VERSION;
      cfg.type_lo <= RST_TYPE_LO;
      cfg.type_hi <= RST_TYPE_HI;
      cfg.max_len <= RST_MAX_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:   cfg.magic   <= cfg_data[15:0];
        CFG_VERSION: cfg.version <= cfg_data[7:0];
        CFG_TYPE_LO: cfg.type_lo <= cfg_data[7:0];
        CFG_TYPE_HI: cfg.type_hi <= cfg_data[7:0];
        CFG_MAX_LEN: cfg.max_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s_byte <= stream_byte;
      s_end  <= chunk_end;
    end
  end

  // header check on the full eight bytes
  lpfd_hdr_check u_hdr_check (
    .hdr ({header_shift, s_byte}),
    .cfg (cfg),
    .chk (chk)
  );

  // next state and result
  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    header_shift_next   = header_shift;
    body_remaining_next = body_remaining;
    current_type_next   = current_type;
    res_valid           = 1'b0;
    res_kind            = KIND_BYTE;
    res_type            = 8'd0;
    res_byte            = 8'd0;
    res_last            = 1'b0;
    res_code            = ERR_MAGIC;
    if (advance) begin
      unique case (phase)
        PH_DISCARD: begin
          if (s_end) begin
            phase_next        = PH_HEADER;
            header_count_next = 3'd0;
          end
        end
        PH_BODY: begin
          body_remaining_next = rem_dec;
          res_valid           = 1'b1;
          res_kind            = KIND_BYTE;
          res_type            = current_type;
          res_byte            = s_byte;
          res_last            = (rem_dec == 32'd0);
          if (rem_dec == 32'd0) begin
            phase_next        = PH_HEADER;
            header_count_next = 3'd0;
          end
        end
        default: begin
          phase_next = PH_HEADER;
          if (header_count != 3'd7) begin
            header_shift_next = {header_shift[47:0], s_byte};
            header_count_next = header_count + 3'd1;
          end else begin
            header_count_next = 3'd0;
            header_shift_next = 56'd0;
            if (chk.bad) begin
              // drop up to the chunk end unless this beat closes it
              phase_next = s_end ? PH_HEADER : PH_DISCARD;
              res_valid  = 1'b1;
              res_kind   = KIND_ERROR;
              res_code   = chk.code;
            end else begin
              current_type_next = chk.msg_type;
              if (chk.empty) begin
                res_valid = 1'b1;
                res_kind  = KIND_EMPTY;
                res_type  = chk.msg_type;
                res_last  = 1'b1;
              end else begin
                body_remaining_next = chk.len;
                phase_next          = PH_BODY;
              end
            end
          end
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      header_count   <= 3'd0;
      header_shift   <= 56'd0;
      body_remaining <= 32'd0;
      current_type   <= 8'd0;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      header_shift   <= header_shift_next;
      body_remaining <= body_remaining_next;
      current_type   <= current_type_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && res_valid) begin
      result_kind     <= res_kind;
      message_type    <= res_type;
      body_byte       <= res_byte;
      last_of_message <= res_last;
      error_code      <= res_code;
    end
  end

endmodule

@@ design/lpfd_hdr_check.sv @@
module lpfd_hdr_check import lpfd_pkg::*; (
  input  logic [HDR_BITS-1:0] hdr,
  input  cfg_t                cfg,
  output hdr_chk_t            chk
);

  logic [15:0] magic;
  logic [7:0]  version;
  logic [7:0]  msg_type;
  logic [31:0] len;

  // big-endian field split
  assign magic    = hdr[63:48];
  assign version  = hdr[47:40];
  assign msg_type = hdr[39:32];
  assign len      = hdr[31:0];

  // checks in priority order, first failure wins
  always_comb begin
    chk.bad      = 1'b1;
    chk.code     = ERR_MAGIC;
    chk.empty    = (len == 32'd0);
    chk.msg_type = msg_type;
    chk.len      = len;
    if (magic != cfg.magic) begin
      chk.code = ERR_MAGIC;
    end else if (version != cfg.version) begin
      chk.code = ERR_VERSION;
    end else if ((msg_type < cfg.type_lo) || (msg_type > cfg.type_hi)) begin
      chk.code = ERR_TYPE;
    end else if (len > cfg.max_len) begin
      chk.code = ERR_LENGTH;
    end else begin
      chk.bad = 1'b0;
    end
  end

endmodule

@@ tb/sv/length_prefixed_frame_deframer_core_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_core_tb;
  import lpfd_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int NOISE_MAX_LEN = 1024;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mtype;
    logic [7:0] data;
    logic       last;
    logic [1:0] code;
  } deframe_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  stream_byte;
  logic        chunk_end;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  result_kind;
  logic [7:0]  message_type;
  logic [7:0]  body_byte;
  logic        last_of_message;
  logic [1:0]  error_code;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // shadow registers and parser state
  logic [15:0] shadow_magic;
  logic [7:0]  shadow_version;
  logic [7:0]  shadow_type_lo;
  logic [7:0]  shadow_type_hi;
  logic [31:0] shadow_max_len;
  phase_t      parse_phase;
  logic [2:0]  hdr_count;
  logic [55:0] hdr_bytes;
  logic [31:0] body_left;
  logic [7:0]  msg_type;

  deframe_result_t results_due[$];
  int  mismatches  = 0;
  int  beats_sent  = 0;
  int  quiet_cycles = 0;
  bit  tx_gaps     = 0;
  bit  rx_stalls   = 0;
  bit  hold_request = 0;

  length_prefixed_frame_deframer_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stream_byte(stream_byte),
    .chunk_end(chunk_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .message_type(message_type),
    .body_byte(body_byte),
    .last_of_message(last_of_message),
    .error_code(error_code),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one byte through the parser, queue whatever it yields
  task automatic decode_byte(input logic [7:0] b, input logic closes);
    deframe_result_t r;
    logic [63:0] hdr;
    logic [15:0] f_magic;
    logic [7:0]  f_version;
    logic [7:0]  f_type;
    logic [31:0] f_len;
    r = '0;
    case (parse_phase)
      PH_DISCARD: begin
        if (closes) begin
          parse_phase = PH_HEADER;
          hdr_count = '0;
        end
      end
      PH_BODY: begin
        body_left = body_left - 32'd1;
        r.kind = KIND_BYTE;
        r.mtype = msg_type;
        r.data = b;
        r.last = (body_left == 0);
        if (body_left == 0) begin
          parse_phase = PH_HEADER;
          hdr_count = '0;
        end
        results_due.push_back(r);
      end
      default: begin
        parse_phase = PH_HEADER;
        if (hdr_count < 3'd7) begin
          hdr_bytes = {hdr_bytes[47:0], b};
          hdr_count = hdr_count + 3'd1;
        end else begin
          hdr = {hdr_bytes, b};
          f_magic = hdr[63:48];
          f_version = hdr[47:40];
          f_type = hdr[39:32];
          f_len = hdr[31:0];
          hdr_count = '0;
          hdr_bytes = '0;
          r.kind = KIND_ERROR;
          if (f_magic != shadow_magic) r.code = ERR_MAGIC;
          else if (f_version != shadow_version) r.code = ERR_VERSION;
          else if (f_type < shadow_type_lo || f_type > shadow_type_hi) r.code = ERR_TYPE;
          else if (f_len > shadow_max_len) r.code = ERR_LENGTH;
          else r.kind = KIND_EMPTY;
          if (r.kind == KIND_ERROR) begin
            parse_phase = closes ? PH_HEADER : PH_DISCARD;
            results_due.push_back(r);
          end else begin
            msg_type = f_type;
            if (f_len == 0) begin
              r.mtype = f_type;
              r.last = 1'b1;
              results_due.push_back(r);
            end else begin
              body_left = f_len;
              parse_phase = PH_BODY;
            end
          end
        end
      end
    endcase
  endtask

  // offer one beat, optionally after a gap, and wait for it to be taken
  task automatic send_beat(input logic [7:0] b, input logic closes);
    if (tx_gaps && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    chunk_end <= closes;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, closes);
    beats_sent++;
  endtask

  task automatic send_header(input logic [63:0] hdr, input logic [7:0] closes);
    for (int i = 0; i < 8; i++) send_beat(hdr[63 - 8 * i -: 8], closes[7 - i]);
  endtask

  // bring the parser back to the start of a header
  task automatic resync();
    while (!(parse_phase == PH_HEADER && hdr_count == 0)) begin
      if (parse_phase == PH_DISCARD) send_beat(8'($urandom), $urandom_range(0, 2) == 0);
      else send_beat(8'($urandom), $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic send_frame(input logic [15:0] magic, input logic [7:0] ver,
                            input logic [7:0] typ, input logic [31:0] len,
                            input logic close_last);
    logic [7:0] closes;
    for (int i = 1; i < 8; i++) closes[i] = ($urandom_range(0, 5) == 0);
    closes[0] = close_last;
    send_header({magic, ver, typ, len}, closes);
    // body bytes, or dropped bytes up to the chunk end after an error
    if (parse_phase == PH_DISCARD) repeat ($urandom_range(0, 5)) send_beat(8'($urandom), 1'b0);
    resync();
  endtask

  task automatic random_frame();
    logic [15:0] magic;
    logic [7:0]  ver;
    logic [7:0]  typ;
    logic [31:0] len;
    logic [31:0] cap;
    int pick;
    int r;
    bit broken;
    magic = shadow_magic;
    ver = shadow_version;
    len = $urandom;
    broken = 1'b1;
    if (shadow_type_lo <= shadow_type_hi)
      typ = 8'($urandom_range(shadow_type_lo, shadow_type_hi));
    else typ = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 86 && shadow_max_len <= NOISE_MAX_LEN) begin
      // stray bytes that break the frame alignment
      repeat ($urandom_range(1, 7)) send_beat(8'($urandom), $urandom_range(0, 3) == 0);
      resync();
    end else begin
      if (pick >= 80 && shadow_max_len != '1) begin
        if ($urandom_range(0, 2) == 0) len = shadow_max_len + 1;
        else len = 32'(64'(shadow_max_len) + 1 +
                       ({32'd0, $urandom} % (64'hFFFF_FFFF - 64'(shadow_max_len))));
      end else if (pick >= 74 && !(shadow_type_lo == 0 && shadow_type_hi == 8'hFF)) begin
        do typ = 8'($urandom); while (typ >= shadow_type_lo && typ <= shadow_type_hi);
      end else if (pick >= 68) begin
        ver = shadow_version ^ 8'($urandom_range(1, 255));
      end else if (pick >= 60) begin
        magic = shadow_magic ^ 16'($urandom_range(1, 65535));
      end else begin
        broken = 1'b0;
        cap = (shadow_max_len < 64) ? shadow_max_len : 32'd64;
        r = $urandom_range(0, 99);
        if (r < 15 || cap == 0) len = 0;
        else if (r < 90) len = $urandom_range(1, (cap < 12) ? cap : 12);
        else len = $urandom_range(1, cap);
      end
      send_frame(magic, ver, typ, len,
                 broken ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 6) == 0));
    end
  endtask

  task automatic run_frames(input int budget);
    int target;
    target = beats_sent + budget;
    while (beats_sent < target) random_frame();
  endtask

  // stop offering and let every pending result come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] magic, input logic [7:0] ver,
                              input logic [7:0] lo, input logic [7:0] hi,
                              input logic [31:0] max_len);
    drain_results();
    write_reg(CFG_MAGIC, {16'd0, magic});
    write_reg(CFG_VERSION, {24'd0, ver});
    write_reg(CFG_TYPE_LO, {24'd0, lo});
    write_reg(CFG_TYPE_HI, {24'd0, hi});
    write_reg(CFG_MAX_LEN, max_len);
    cfg_we <= 1'b0;
    shadow_magic = magic;
    shadow_version = ver;
    shadow_type_lo = lo;
    shadow_type_hi = hi;
    shadow_max_len = max_len;
  endtask

  // bad magic on a chunk-closing byte: nothing dropped after it
  task automatic test_error_at_chunk_end();
    send_header({~RST_MAGIC, RST_VERSION, RST_TYPE_LO, 32'd0}, 8'h01);
  endtask

  // chunk ends inside header and body are ignored
  task automatic test_short_body();
    send_header({RST_MAGIC, RST_VERSION, RST_TYPE_LO, 32'd2}, 8'b0001_0000);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
  endtask

  task automatic test_empty_message();
    send_header({RST_MAGIC, RST_VERSION, RST_TYPE_HI, 32'd0}, 8'h00);
  endtask

  task automatic test_default_config();
    tx_gaps = 1;
    rx_stalls = 1;
    run_frames(200);
    // a stretch with no idling on either side
    tx_gaps = 0;
    rx_stalls = 0;
    run_frames(150);
    tx_gaps = 1;
    rx_stalls = 1;
  endtask

  task automatic test_wide_open_config();
    write_config(16'hFFFF, 8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF);
    run_frames(200);
  endtask

  // lowest above highest: every type is unknown
  task automatic test_inverted_type_range();
    write_config(16'h0000, 8'h00, 8'h80, 8'h7F, 32'd0);
    run_frames(150);
  endtask

  task automatic test_random_configs();
    logic [7:0] lo;
    repeat (5) begin
      lo = 8'($urandom_range(0, 200));
      write_config(16'($urandom), 8'($urandom), lo, 8'($urandom_range(lo, 255)),
                   $urandom_range(0, 300));
      run_frames(100);
    end
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_config(RST_MAGIC, RST_VERSION, RST_TYPE_LO, RST_TYPE_HI, RST_MAX_LEN);
    hold_request = 1;
    while (hold_request) random_frame();
    run_frames(60);
  endtask

  // sender waits for every result before going on
  task automatic test_drain_pause();
    repeat (5) begin
      run_frames(20);
      drain_results();
    end
  endtask

  // receiver ready with random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 99) < 20) stall_left = gap_len();
      end
    end
  end

  // compare each output beat with the oldest pending result
  always @(posedge clk) begin : result_check
    deframe_result_t want;
    deframe_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = result_kind;
      got.mtype = message_type;
      got.data = body_byte;
      got.last = last_of_message;
      got.code = error_code;
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d type %h byte %h last %b code %0d",
                   got.kind, got.mtype, got.data, got.last, got.code);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("mismatch: want kind %0d type %h byte %h last %b code %0d,",
                     want.kind, want.mtype, want.data, want.last, want.code,
                     " got kind %0d type %h byte %h last %b code %0d",
                     got.kind, got.mtype, got.data, got.last, got.code);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    stream_byte = '0;
    chunk_end = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shadow_magic = RST_MAGIC;
    shadow_version = RST_VERSION;
    shadow_type_lo = RST_TYPE_LO;
    shadow_type_hi = RST_TYPE_HI;
    shadow_max_len = RST_MAX_LEN;
    parse_phase = PH_HEADER;
    hdr_count = '0;
    hdr_bytes = '0;
    body_left = '0;
    msg_type = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_error_at_chunk_end();
    test_short_body();
    test_empty_message();
    test_default_config();
    test_wide_open_config();
    test_inverted_type_range();
    test_random_configs();
    test_output_backpressure();
    test_drain_pause();
    drain_results();

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lpfd_pkg.sv
design/lpfd_hdr_check.sv
design/length_prefixed_frame_deframer_core.sv
tb/sv/length_prefixed_frame_deframer_core_tb.sv
